/* rtl/core/rsc_pkg.sv */
// Shared constants for the RV32 subset core: item codes, opcodes and field widths.
package rsc_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 16;
  localparam int WORD_W = 32;
  localparam int REG_W  = 5;
  localparam int CFG_W  = 16;

  localparam logic [FUNC_W-1:0] FUNC_WR_MEM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RD_MEM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXEC   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_REG = 2'd3;

  localparam logic [6:0] OP_RTYPE  = 7'h33;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] F7_SUB    = 7'h20;
  localparam logic [6:0] F7_ADD    = 7'h00;
  localparam logic [2:0] F3_ADD    = 3'd0;

endpackage

/* rtl/core/rsc_req_if.sv */
// Request channel carrying one core command per transaction.
interface rsc_req_if;
  import rsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] mem_address;
  logic [WORD_W-1:0] write_word;
  logic [REG_W-1:0]  reg_index;

  modport source (output valid, func, mem_address, write_word, reg_index, input ready);
  modport sink (input valid, func, mem_address, write_word, reg_index, output ready);
endinterface

/* rtl/core/rsc_rsp_if.sv */
// Response channel carrying one core result per transaction.
interface rsc_rsp_if;
  import rsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_word;
  logic [WORD_W-1:0] pc_value;
  logic              status;

  modport source (output valid, read_word, pc_value, status, input ready);
  modport sink (input valid, read_word, pc_value, status, output ready);
endinterface

/* rtl/core/rv32_subset_core_step.sv */
// Multicycle RV32 subset core with a byte-banked data memory and a register file memory.
//
// Channel    Direction  Contents
// req        in         func, mem_address, write_word, reg_index
// rsp        out        read_word, pc_value, status
// cfg        in         start_pc write (cfg_write, cfg_data)
//
// Memory writes, memory reads and register reads go from the accept to S_WDONE,
// S_MRD or S_RRD, which issues the result. An execute transaction runs fetch,
// register read, then execute or a second access to the single-ported byte banks.
// After reset the memory is cleared one row of four bytes per cycle, (MEM_BYTES+3)/4
// rows in all, while req.ready stays low.
// A result waits in the rsp register; the core stalls at the end of the next
// transaction until that register is free.
module rv32_subset_core_step #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rsc_pkg::CFG_W-1:0]   cfg_data,
  rsc_req_if.sink                     req,
  rsc_rsp_if.source                   rsp
);
  import rsc_pkg::*;

  localparam int ROWS = (MEM_BYTES + 3) / 4;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MEM_BYTES - 4);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WDONE = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_RRD   = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_EXEC  = 3'd6;
  localparam logic [2:0] S_LOAD  = 3'd7;

  logic [2:0]        state, state_next;
  logic [ROW_W-1:0]  clr_row;
  logic              clr_last;
  logic [WORD_W-1:0] pc, pc_next;
  logic [WORD_W-1:0] inst;
  logic              accept, out_free, fin;
  logic [WORD_W-1:0] res_word;
  logic              res_status;

  logic [WORD_W-1:0] acc_addr, acc_data;
  logic              acc_rd, acc_wr, acc_fit;
  logic [1:0]        acc_off;
  logic [ROW_W-1:0]  acc_row;
  logic [ROW_W-1:0]  bank_row [4];
  logic              bank_we [4];
  logic [7:0]        bank_wd [4];
  logic [7:0]        bank_q [4];
  logic [1:0]        rd_off;
  logic              rd_fit;
  logic [WORD_W-1:0] mem_word;

  logic [WORD_W-1:0] rf_mem [32];
  logic [31:0]       rf_valid;
  logic [WORD_W-1:0] rfa_q, rfb_q, a_val, b_val;
  logic              rfa_v, rfb_v, rf_re, rf_we;
  logic [4:0]        rfa_addr, rfb_addr, rf_wa;
  logic [WORD_W-1:0] rf_wd;

  logic [6:0]        op, f7;
  logic [2:0]        f3;
  logic [WORD_W-1:0] imm_i, imm_s, alu_res;
  logic              is_load, known, alu_we;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free = !rsp.valid || rsp.ready;
  assign clr_last = (clr_row == ROW_W'(ROWS - 1));

  assign op    = inst[6:0];
  assign f3    = inst[14:12];
  assign f7    = inst[31:25];
  assign rf_wa = inst[11:7];
  assign imm_i = {{20{inst[31]}}, inst[31:20]};
  assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign a_val = rfa_v ? rfa_q : '0;
  assign b_val = rfb_v ? rfb_q : '0;
  assign is_load = (op == OP_LOAD);

  always_comb begin
    known = 1'b1;
    alu_we = 1'b0;
    alu_res = a_val + imm_i;
    unique case (op)
      OP_RTYPE: begin
        alu_we = (f3 == F3_ADD) && (f7 == F7_ADD || f7 == F7_SUB);
        alu_res = (f7 == F7_SUB) ? a_val - b_val : a_val + b_val;
      end
      OP_ALUI: begin
        alu_we = 1'b1;
      end
      OP_LOAD, OP_STORE, OP_BRANCH, OP_AUIPC, OP_LUI, OP_JAL: begin
        alu_we = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_addr = '0;
    acc_data = '0;
    acc_rd = 1'b0;
    acc_wr = 1'b0;
    if (state == S_IDLE && accept) begin
      acc_addr = (req.func == FUNC_EXEC) ? pc : {16'b0, req.mem_address};
      acc_data = req.write_word;
      acc_rd = (req.func == FUNC_RD_MEM) || (req.func == FUNC_EXEC);
      acc_wr = (req.func == FUNC_WR_MEM);
    end else if (state == S_EXEC) begin
      if (is_load) begin
        acc_addr = a_val + imm_i;
        acc_rd = 1'b1;
      end else if (op == OP_STORE && out_free) begin
        acc_addr = a_val + imm_s;
        acc_data = b_val;
        acc_wr = 1'b1;
      end
    end
  end

  assign acc_fit = (acc_addr <= LAST_WORD);
  assign acc_off = acc_addr[1:0];
  assign acc_row = acc_addr[ROW_W+1:2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (state == S_CLEAR) begin
        bank_row[k] = clr_row;
        bank_we[k] = 1'b1;
        bank_wd[k] = '0;
      end else begin
        bank_row[k] = acc_row + ROW_W'(2'(k) < acc_off);
        bank_we[k] = acc_wr && acc_fit;
        bank_wd[k] = acc_data[8*(2'(2'(k) - acc_off)) +: 8];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic [7:0] q;
    always_ff @(posedge clk) begin
      if (bank_we[k]) begin
        mem[bank_row[k]] <= bank_wd[k];
      end else if (acc_rd) begin
        q <= mem[bank_row[k]];
      end
    end
    assign bank_q[k] = q;
  end

  always_ff @(posedge clk) begin
    if (acc_rd) begin
      rd_off <= acc_off;
      rd_fit <= acc_fit;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mem_word[8*i +: 8] = rd_fit ? bank_q[2'(rd_off + 2'(i))] : 8'h00;
    end
  end

  assign rfa_addr = (state == S_IDLE) ? req.reg_index : mem_word[19:15];
  assign rfb_addr = mem_word[24:20];
  assign rf_re = (state == S_IDLE && accept && req.func == FUNC_RD_REG) || (state == S_FETCH);
  assign rf_we = (rf_wa != 5'd0) && out_free &&
                 ((state == S_EXEC && alu_we) || (state == S_LOAD));
  assign rf_wd = (state == S_LOAD) ? mem_word : alu_res;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (rf_re) begin
      rfa_q <= rf_mem[rfa_addr];
      rfb_q <= rf_mem[rfb_addr];
      rfa_v <= rf_valid[rfa_addr];
      rfb_v <= rf_valid[rfb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_wa] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    fin = 1'b0;
    res_word = '0;
    res_status = 1'b0;
    pc_next = pc;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req.func)
            FUNC_WR_MEM: state_next = S_WDONE;
            FUNC_RD_MEM: state_next = S_MRD;
            FUNC_EXEC:   state_next = S_FETCH;
            default:     state_next = S_RRD;
          endcase
        end
      end
      S_WDONE: begin
        fin = out_free;
      end
      S_MRD: begin
        fin = out_free;
        res_word = mem_word;
      end
      S_RRD: begin
        fin = out_free;
        res_word = a_val;
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_load) begin
          state_next = S_LOAD;
        end else begin
          fin = out_free;
          res_status = !known;
          if (out_free && known) begin
            pc_next = pc + 32'd4;
          end
        end
      end
      default: begin
        fin = out_free;
        if (out_free) begin
          pc_next = pc + 32'd4;
        end
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_row <= '0;
      pc <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (cfg_write) begin
        pc <= {16'b0, cfg_data};
      end else begin
        pc <= pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      inst <= mem_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fin) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp.read_word <= res_word;
      rsp.pc_value <= pc_next;
      rsp.status <= res_status;
    end
  end

  a_x0_never_written: assert property (@(posedge clk) disable iff (rst)
    !rf_valid[0])
    else $error("Register x0 was marked as written.");

  a_load_follows_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> ($past(state) == S_LOAD || $past(state) == S_EXEC))
    else $error("Load completion entered without an execute step.");

  a_pc_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !is_load && known && out_free && !cfg_write) |=>
      (pc == $past(pc) + 32'd4))
    else $error("Program counter did not advance after a known instruction.");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    fin |-> (!rsp.valid || rsp.ready))
    else $error("A result overwrote a pending response.");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR && bank_we[0]) |-> acc_fit)
    else $error("Memory written by an out-of-range access.");

endmodule
